// ===== hdl/clcd_pkg.sv =====
`timescale 1ns / 1ps

package clcd_pkg;

    localparam int ROWS = 4;
    localparam int COLS = 20;

    localparam int IN_W  = 24;
    localparam int OUT_W = 48;

    localparam logic [4:0] INIT_LAST = 5'd18;
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;
    localparam logic [7:0] CMD_DDRAM = 8'h80;
    localparam logic [7:0] BUS_LIGHT = 8'h08;
    localparam logic [7:0] BUS_EN    = 8'h04;
    localparam logic [5:0] WAIT_POWER = 6'd60;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_CMD    = 3'd1,
        OP_DATA   = 3'd2,
        OP_CURSOR = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_LIGHT  = 3'd5,
        OP_FAIL   = 3'd6,
        OP_LINE   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        SRC_INIT  = 2'd0,
        SRC_BODY  = 2'd1,
        SRC_LIGHT = 2'd2
    } t_src;

    typedef struct packed {
        logic       load;
        logic       emit;
        t_src       src;
        logic [4:0] step;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
    } t_dp_stat;

    typedef struct packed {
        logic       single;
        logic [3:0] nib;
        logic [2:0] wait_after;
    } t_init_ent;

    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        unique case (r)
            2'd0: b = 8'h00;
            2'd1: b = 8'h40;
            2'd2: b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    function automatic t_init_ent init_rom(input logic [4:0] idx);
        t_init_ent e;
        e = '{single: 1'b0, nib: 4'h0, wait_after: 3'd0};
        unique case (idx)
            5'd0:  e = '{single: 1'b1, nib: 4'h0, wait_after: 3'd5};
            5'd1:  e.nib = 4'h3;
            5'd2:  e.nib = 4'h3;
            5'd3:  e.nib = 4'h3;
            5'd4:  e.nib = 4'h2;
            5'd5:  e.nib = 4'h2;
            5'd6:  e.nib = 4'h8;
            5'd7:  e.nib = 4'h2;
            5'd8:  e.nib = 4'h8;
            5'd9:  e.nib = 4'h0;
            5'd10: e.nib = 4'h8;
            5'd11: e.nib = 4'h0;
            5'd12: e.nib = 4'h1;
            5'd13: e.nib = 4'h0;
            5'd14: e.nib = 4'h6;
            5'd15: e.nib = 4'h0;
            5'd16: e.nib = 4'hC;
            5'd17: e.nib = 4'h0;
            5'd18: e.nib = 4'h2;
            default: e.nib = 4'h0;
        endcase
        unique case (idx)
            5'd1, 5'd2:                       e.wait_after = 3'd5;
            5'd3, 5'd4:                       e.wait_after = 3'd2;
            5'd6, 5'd8, 5'd10, 5'd14, 5'd16:  e.wait_after = 3'd1;
            5'd12, 5'd18:                     e.wait_after = 3'd3;
            default:                          ;
        endcase
        return e;
    endfunction

endpackage

// ===== hdl/char_lcd_i2c_expander_sequencer_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  tdata fields (low bit first)                              Flags
// s_axis    in         operation[2:0] payload_byte[10:3] row[13:11] column[18:14]  -
// m_axis    out        slave_address[6:0] byte_count[8:7] first_byte[16:9]
//                      second_byte[24:17] third_byte[32:25] wait_before_ms[38:33]
//                      wait_after_ms[41:39]                                        tlast=last
// cfg       in         i_cfg_wdata = device_address, written when i_cfg_we is high
//
// A request is accepted while the controller is idle, and then each transaction it causes is issued,
// up to 23 beats for a clear that has to initialize the display first.
// The controller steps through the transactions one a cycle into a single output register.
// A stalled output holds the controller; a new request is taken once the previous one has issued.
// Reset is synchronous and active low; the display starts uninitialized with the backlight on.

module char_lcd_i2c_expander_sequencer_top
    import clcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // operation, payload_byte, row, column
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // slave_address, byte_count, first_byte,
                                             // second_byte, third_byte, wait_before_ms,
                                             // wait_after_ms
    output logic             m_axis_tlast,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    clcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tdata[2:0]),
        .i_row      (s_axis_tdata[13:11]),
        .i_column   (s_axis_tdata[18:14]),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    clcd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_axis_tdata[2:0]),
        .i_payload   (s_axis_tdata[10:3]),
        .i_row       (s_axis_tdata[13:11]),
        .i_column    (s_axis_tdata[18:14]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

// ===== hdl/clcd_ctrl.sv =====
`timescale 1ns / 1ps

module clcd_ctrl
    import clcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [2:0] i_op,
    input  logic [2:0] i_row,
    input  logic [4:0] i_column,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_INIT  = 4'b0010,
        ST_BODY  = 4'b0100,
        ST_LIGHT = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic       r_ready, n_ready;
    logic [4:0] r_step, n_step;
    logic       r_has_body, n_has_body;
    logic [1:0] r_body_last, n_body_last;

    logic row_ok, col_ok, needs, run_init, accept;

    assign row_ok = {1'b0, i_row} < 4'(ROWS);
    assign col_ok = {1'b0, i_column} < 6'(COLS);
    assign accept = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        unique case (t_op'(i_op))
            OP_CMD, OP_DATA, OP_CLEAR: needs = 1'b1;
            OP_CURSOR:                 needs = row_ok && col_ok;
            OP_LINE:                   needs = row_ok;
            default:                   needs = 1'b0;
        endcase
    end

    assign run_init = (t_op'(i_op) == OP_INIT) || (needs && !r_ready);

    always_comb begin
        n_state     = r_state;
        n_ready     = r_ready;
        n_step      = r_step;
        n_has_body  = r_has_body;
        n_body_last = r_body_last;
        o_cmd       = '{load: 1'b0, emit: 1'b0, src: SRC_INIT, step: r_step, last: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load  = 1'b1;
                    n_step      = '0;
                    n_has_body  = needs;
                    n_body_last = (t_op'(i_op) == OP_CLEAR) ? 2'd3 : 2'd1;
                    if (t_op'(i_op) == OP_LIGHT) begin
                        n_state = ST_LIGHT;
                    end else if (t_op'(i_op) == OP_FAIL) begin
                        n_ready = 1'b0;
                    end else if (run_init) begin
                        n_state = ST_INIT;
                    end else if (needs) begin
                        n_state = ST_BODY;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.src  = SRC_INIT;
                o_cmd.last = (r_step == INIT_LAST) && !r_has_body;
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_step == INIT_LAST) begin
                        n_ready = 1'b1;
                        n_step  = '0;
                        n_state = r_has_body ? ST_BODY : ST_IDLE;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
            end
            ST_BODY: begin
                o_cmd.src  = SRC_BODY;
                o_cmd.last = (r_step[1:0] == r_body_last);
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_step     = r_step + 5'd1;
                    if (r_step[1:0] == r_body_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_LIGHT: begin
                o_cmd.src  = SRC_LIGHT;
                o_cmd.last = 1'b1;
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ready     <= 1'b0;
            r_step      <= '0;
            r_has_body  <= 1'b0;
            r_body_last <= 2'd1;
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_step      <= n_step;
            r_has_body  <= n_has_body;
            r_body_last <= n_body_last;
        end
    end

endmodule

// ===== hdl/clcd_dp.sv =====
`timescale 1ns / 1ps

module clcd_dp
    import clcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [2:0]       i_op,
    input  logic [7:0]       i_payload,
    input  logic [2:0]       i_row,
    input  logic [4:0]       i_column,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_wdata,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_data,
    output logic             o_last
);

    logic [6:0] r_addr;
    logic       r_light;
    logic [7:0] r_byte0;
    logic       r_rs;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_last;

    logic [7:0] load_byte;
    t_init_ent  ent;
    logic [7:0] body_byte;
    logic       single, rs;
    logic [3:0] nib;
    logic [2:0] wa;
    logic [5:0] wb;
    logic [7:0] bus, b0, b1, b2;
    logic [1:0] cnt;

    always_comb begin
        unique case (t_op'(i_op))
            OP_CURSOR: load_byte = CMD_DDRAM | (row_base(i_row[1:0]) + {3'b000, i_column});
            OP_LINE:   load_byte = CMD_DDRAM | row_base(i_row[1:0]);
            OP_CLEAR:  load_byte = CMD_CLEAR;
            default:   load_byte = i_payload;
        endcase
    end

    assign ent       = init_rom(i_cmd.step);
    assign body_byte = i_cmd.step[1] ? CMD_HOME : r_byte0;

    always_comb begin
        single = 1'b0;
        rs     = 1'b0;
        nib    = 4'h0;
        wa     = 3'd0;
        wb     = 6'd0;
        unique case (i_cmd.src)
            SRC_INIT: begin
                single = ent.single;
                nib    = ent.nib;
                wa     = ent.wait_after;
                wb     = (i_cmd.step == 5'd0) ? WAIT_POWER : 6'd0;
            end
            SRC_BODY: begin
                rs  = r_rs && !i_cmd.step[1];
                nib = i_cmd.step[0] ? body_byte[3:0] : body_byte[7:4];
                if (i_cmd.step[0]) begin
                    wa = (!rs && (body_byte == CMD_CLEAR || body_byte == CMD_HOME))
                         ? 3'd3 : 3'd1;
                end
            end
            default: single = 1'b1;
        endcase
    end

    always_comb begin
        bus = {nib, r_light, 2'b00, rs};
        if (single) begin
            cnt = 2'd1;
            b0  = r_light ? BUS_LIGHT : 8'h00;
            b1  = 8'h00;
            b2  = 8'h00;
        end else begin
            cnt = 2'd3;
            b0  = bus;
            b1  = bus | BUS_EN;
            b2  = bus;
        end
    end

    assign o_stat.slot_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= 7'h27;
            r_light     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_addr <= i_cfg_wdata;
            end
            if (i_cmd.load && t_op'(i_op) == OP_LIGHT) begin
                r_light <= i_payload[0];
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte0 <= load_byte;
            r_rs    <= (t_op'(i_op) == OP_DATA);
        end
        if (i_cmd.emit) begin
            r_out_data <= {6'b0, wa, wb, b2, b1, b0, cnt, r_addr};
            r_out_last <= i_cmd.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule
